>>> rtl/core/hmg_pkg.sv
package hmg_pkg;

  localparam int MAX_EDGE = 1024;
  localparam int POS_W    = 10;
  localparam int CFG_W    = 11;
  localparam int HEIGHT_W = 16;
  localparam int DIFF_W   = HEIGHT_W + 1;
  localparam int SQ_W     = 2 * HEIGHT_W + 1;
  localparam int S_W      = SQ_W + 1;
  localparam int N_W      = SQ_W + 30;
  localparam int K_W      = 17;
  localparam int UW       = 70;
  localparam int TEX_W    = 17;
  localparam int NRM_W    = 16;
  localparam int DATA_W   = 120;

  typedef struct packed {
    logic start;
    logic sq;
  } unit_cmd_t;

endpackage

>>> rtl/core/hmg_ram.sv
module hmg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/hmg_unit.sv
module hmg_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  hmg_pkg::unit_cmd_t        cmd,
  input  logic [hmg_pkg::S_W-1:0]   s_op,
  input  logic [hmg_pkg::N_W-1:0]   n_op,
  output logic                      done,
  output logic [hmg_pkg::K_W-1:0]   k
);
  import hmg_pkg::*;

  // bitwise search for the largest k with k*s <= n, or k*k*s <= n
  logic          busy;
  logic          sq_mode;
  logic [4:0]    step;
  logic [UW-1:0] p;
  logic [UW-1:0] qsh;
  logic [UW-1:0] ss;
  logic [UW-1:0] sl;
  logic [UW-1:0] n;
  logic [UW-1:0] trial;
  logic [UW-1:0] qsh_next;
  logic          acc;

  always_comb begin
    trial    = p + (sq_mode ? (qsh + ss) : sl);
    acc      = (trial <= n);
    qsh_next = (acc && sq_mode) ? (qsh + (ss << 1)) : qsh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy    <= 1'b1;
        step    <= 5'(K_W - 1);
        sq_mode <= cmd.sq;
        p       <= '0;
        qsh     <= '0;
        k       <= '0;
        ss      <= UW'(s_op) << (2 * (K_W - 1));
        sl      <= UW'(s_op) << (K_W - 1);
        n       <= UW'(n_op);
      end else if (busy) begin
        if (acc) begin
          p <= trial;
        end
        k    <= {k[K_W-2:0], acc};
        qsh  <= qsh_next >> 1;
        ss   <= ss >> 2;
        sl   <= sl >> 1;
        step <= step - 5'd1;
        if (step == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/heightmap_mesh_generator.sv
// channel   | dir | fields (low bit up)
// s_*       | in  | tdata: height[15:0]
// m_*       | out | tdata: pos_x, pos_y, pos_z, tex_u, tex_v, normal_x/y/z; tlast: last_of_cell;
//           |     | tuser: last_of_mesh
// cfg_*     | in  | mesh_edge write
// A height in row 0 or column 0 passes only the idle and line store read states.
// A height closing a cell has its first vertex appear after a line store read, four squares,
// one sum, then ten 17-step searches on the one shared search unit.
// The six vertices then leave one per transfer; output stalls extend the item.
// Reset (rst, synchronous) clears counters, left heights, and sets mesh_edge to 2.
module heightmap_mesh_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,  // height
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [hmg_pkg::DATA_W-1:0]   m_tdata,  // pos_x,pos_y,pos_z,tex_u,tex_v,nx,ny,nz
  output logic                         m_tlast,  // last_of_cell
  output logic                         m_tuser,  // last_of_mesh
  input  logic                         cfg_wen,
  input  logic [hmg_pkg::CFG_W-1:0]    cfg_wdata
);
  import hmg_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_SQ    = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_JSET  = 3'd4;
  localparam logic [2:0] ST_JWAIT = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  localparam logic [3:0] JOB_LAST = 4'd9;
  localparam logic [3:0] JOB_TEX  = 4'd6;

  logic [2:0]          state;
  logic [CFG_W-1:0]    mesh_edge;
  logic [POS_W-1:0]    column_count;
  logic [POS_W-1:0]    row_count;
  logic [HEIGHT_W-1:0] left_height;
  logic [HEIGHT_W-1:0] left_above_height;
  logic [HEIGHT_W-1:0] hreg;
  logic [POS_W-1:0]    ci_reg;
  logic                has_cell;
  logic                lm_reg;
  logic [POS_W-1:0]    xr, zr, c_reg, r_reg;
  logic [HEIGHT_W-1:0] h0, h1, h2, h5;
  logic [SQ_W-1:0]     sqr [4];
  logic [S_W-1:0]      s1, s2;
  logic [1:0]          sq_idx;
  logic [3:0]          jidx;
  logic [2:0]          vi;
  logic signed [NRM_W-1:0] nrm [6];
  logic [TEX_W-1:0]    tex [4];
  logic [CFG_W-1:0]    eff;
  logic [POS_W-1:0]    em1;
  logic                accept;
  logic [HEIGHT_W-1:0] rdata;
  logic signed [DIFF_W-1:0] dif [4];
  logic [DIFF_W-1:0]   absd;
  logic [2*DIFF_W-1:0] prod;
  unit_cmd_t           cmd;
  logic [S_W-1:0]      s_op;
  logic [N_W-1:0]      n_op;
  logic                u_done;
  logic [K_W-1:0]      u_k;
  logic [K_W:0]        mround;
  logic                neg;
  logic [POS_W-1:0]    tpos;
  logic [SQ_W-1:0]     sqv;
  logic                second_tri;
  logic [POS_W-1:0]    px, pz;
  logic [HEIGHT_W-1:0] py;

  always_comb begin
    if (mesh_edge < CFG_W'(2)) begin
      eff = CFG_W'(2);
    end else if (mesh_edge > CFG_W'(MAX_EDGE)) begin
      eff = CFG_W'(MAX_EDGE);
    end else begin
      eff = mesh_edge;
    end
    em1 = POS_W'(eff - CFG_W'(1));
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  hmg_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_EDGE)) u_row_store (
    .clk   (clk),
    .we    (state == ST_RD),
    .waddr (ci_reg),
    .wdata (hreg),
    .raddr (column_count),
    .rdata (rdata)
  );

  always_comb begin
    dif[0] = DIFF_W'(signed'(h0)) - DIFF_W'(signed'(h2));
    dif[1] = DIFF_W'(signed'(h0)) - DIFF_W'(signed'(h1));
    dif[2] = DIFF_W'(signed'(h1)) - DIFF_W'(signed'(h5));
    dif[3] = DIFF_W'(signed'(h2)) - DIFF_W'(signed'(h5));
    absd   = dif[sq_idx][DIFF_W-1] ? DIFF_W'(-dif[sq_idx]) : DIFF_W'(dif[sq_idx]);
    prod   = absd * absd;
  end

  // job operands: 0..5 normal components, 6..9 texture coordinates
  always_comb begin
    cmd.start = (state == ST_JSET);
    cmd.sq    = (jidx < JOB_TEX);
    sqv       = SQ_W'(65536);
    neg       = 1'b0;
    case (jidx)
      4'd0: begin sqv = sqr[0]; neg = dif[0][DIFF_W-1]; end
      4'd2: begin sqv = sqr[1]; neg = dif[1][DIFF_W-1]; end
      4'd3: begin sqv = sqr[2]; neg = dif[2][DIFF_W-1]; end
      4'd5: begin sqv = sqr[3]; neg = dif[3][DIFF_W-1]; end
      default: ;
    endcase
    case (jidx)
      4'd6:    tpos = xr;
      4'd7:    tpos = c_reg;
      4'd8:    tpos = zr;
      default: tpos = r_reg;
    endcase
    if (cmd.sq) begin
      s_op = (jidx < 4'd3) ? s1 : s2;
      n_op = N_W'(sqv) << 30;
    end else begin
      s_op = S_W'({em1, 1'b0});
      n_op = (N_W'(tpos) << 17) + N_W'(em1);
    end
    mround = {1'b0, u_k} + (K_W+1)'(1);
  end

  hmg_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .s_op (s_op),
    .n_op (n_op),
    .done (u_done),
    .k    (u_k)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      mesh_edge         <= CFG_W'(2);
      column_count      <= '0;
      row_count         <= '0;
      left_height       <= '0;
      left_above_height <= '0;
      sq_idx            <= '0;
      jidx              <= '0;
      vi                <= '0;
    end else begin
      if (cfg_wen) begin
        mesh_edge    <= cfg_wdata;
        column_count <= '0;
        row_count    <= '0;
      end else if (accept) begin
        if (column_count >= em1) begin
          column_count <= '0;
          row_count    <= (row_count >= em1) ? '0 : row_count + POS_W'(1);
        end else begin
          column_count <= column_count + POS_W'(1);
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            hreg     <= s_tdata;
            ci_reg   <= column_count;
            has_cell <= (row_count != '0) && (column_count != '0);
            lm_reg   <= (row_count == em1) && (column_count == em1);
            xr       <= column_count - POS_W'(1);
            zr       <= row_count - POS_W'(1);
            c_reg    <= column_count;
            r_reg    <= row_count;
            state    <= ST_RD;
          end
        end
        ST_RD: begin
          h0                <= left_above_height;
          h1                <= left_height;
          h2                <= rdata;
          h5                <= hreg;
          left_above_height <= rdata;
          left_height       <= hreg;
          sq_idx            <= '0;
          state             <= has_cell ? ST_SQ : ST_IDLE;
        end
        ST_SQ: begin
          sqr[sq_idx] <= SQ_W'(prod);
          sq_idx      <= sq_idx + 2'd1;
          if (sq_idx == 2'd3) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          s1    <= S_W'(sqr[0]) + S_W'(sqr[1]) + S_W'(65536);
          s2    <= S_W'(sqr[2]) + S_W'(sqr[3]) + S_W'(65536);
          jidx  <= '0;
          state <= ST_JSET;
        end
        ST_JSET: begin
          state <= ST_JWAIT;
        end
        ST_JWAIT: begin
          if (u_done) begin
            if (jidx < JOB_TEX) begin
              nrm[jidx[2:0]] <= neg ? -NRM_W'(mround[K_W:1]) : NRM_W'(mround[K_W:1]);
            end else begin
              tex[2'(jidx - JOB_TEX)] <= u_k;
            end
            if (jidx == JOB_LAST) begin
              vi    <= '0;
              state <= ST_EMIT;
            end else begin
              jidx  <= jidx + 4'd1;
              state <= ST_JSET;
            end
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            vi <= vi + 3'd1;
            if (vi == 3'd5) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    second_tri = (vi >= 3'd3);
    px  = (vi inside {3'd0, 3'd1, 3'd4}) ? xr : c_reg;
    pz  = (vi inside {3'd0, 3'd2, 3'd3}) ? zr : r_reg;
    case (vi)
      3'd0:    py = h0;
      3'd1:    py = h1;
      3'd2:    py = h2;
      3'd3:    py = h2;
      3'd4:    py = h1;
      default: py = h5;
    endcase
    m_tvalid = (state == ST_EMIT);
    m_tlast  = (vi == 3'd5);
    m_tuser  = (vi == 3'd5) && lm_reg;
    m_tdata  = {2'b00,
                second_tri ? nrm[5] : nrm[2],
                second_tri ? nrm[4] : nrm[1],
                second_tri ? nrm[3] : nrm[0],
                (pz == zr) ? tex[2] : tex[3],
                (px == xr) ? tex[0] : tex[1],
                pz, py, px};
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("ready while emitting");
  a_cell_end_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("no return to idle");
  a_unit_done: assert property (@(posedge clk) disable iff (rst)
    u_done |-> (state == ST_JWAIT)) else $error("search done out of place");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (column_count <= em1) && (row_count <= em1)) else $error("counter beyond edge");

endmodule
